// ----- hw/rtl/itp_pkg.sv -----
`timescale 1ns / 1ps

package itp_pkg;

  // Default bound on the padded text length
  localparam int unsigned MaxWidthDef = 16;

  // Longest digit string: ten decimal digits for a 32-bit magnitude
  localparam int unsigned MaxDigits = 10;
  localparam int unsigned DigW      = $clog2(MaxDigits + 1);

  // Job queue between front and back
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // Conversion modes
  localparam logic [1:0] ModeUdec  = 2'd0;
  localparam logic [1:0] ModeSdec  = 2'd1;
  localparam logic [1:0] ModeHexLo = 2'd2;
  localparam logic [1:0] ModeHexUp = 2'd3;

  // Character codes
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharUpA   = 8'h41;

  // ceil(2^35 / 10): floor(x / 10) == (x * Recip10) >> 35 for any 32-bit x
  localparam logic [31:0] Recip10    = 32'hCCCCCCCD;
  localparam int unsigned Recip10Shr = 35;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         mode;
    logic [4:0]         min_width;
    logic               zero_pad;
  } in_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } out_t;

  // One classified number, digits least significant first
  typedef struct packed {
    logic [MaxDigits-1:0][3:0] digits;
    logic [DigW-1:0]           n_digits;
    logic                      neg;
    logic                      upper;
    logic                      zero_pad;
    logic [4:0]                width;
  } job_t;

  function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
    logic [7:0] base;
    base = upper ? CharUpA : CharLowA;
    if (d < 4'd10) begin
      return CharZero + {4'b0, d};
    end
    return base + {4'b0, d} - 8'd10;
  endfunction

endpackage

// ----- hw/rtl/itp_fifo.sv -----
`timescale 1ns / 1ps

module itp_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  itp_pkg::job_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output itp_pkg::job_t rdata_o
);

  localparam int unsigned Depth = itp_pkg::FifoDepth;
  localparam int unsigned PtrW  = itp_pkg::FifoPtrW;
  localparam int unsigned CntW  = itp_pkg::FifoCntW;

  itp_pkg::job_t mem_q [Depth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("job queue fill count out of range");
`endif

endmodule

// ----- hw/rtl/itp_front.sv -----
`timescale 1ns / 1ps

module itp_front #(
  parameter int unsigned MAX_WIDTH = itp_pkg::MaxWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  itp_pkg::in_t  in_data_i,
  output logic          job_push_o,
  input  logic          job_full_i,
  output itp_pkg::job_t job_o
);

  localparam int unsigned DigW = itp_pkg::DigW;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StPush = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [31:0] mag_q, mag_d;
  logic        hex_q;
  logic [DigW-1:0] cnt_q, cnt_d;
  itp_pkg::job_t   job_q;

  logic        accept, neg_in, hex_in;
  logic [4:0]  width_sat;
  logic [63:0] prod;
  logic [31:0] quot;
  logic [31:0] dec_rem;
  logic [3:0]  digit;
  logic [31:0] mag_next;

  assign full   = (state_q != StIdle);
  assign accept = push && !full;

  // classify the incoming number
  assign hex_in = in_data_i.mode[1];
  assign neg_in = (in_data_i.mode == itp_pkg::ModeSdec) && in_data_i.value[31];
  assign width_sat = (int'(in_data_i.min_width) > MAX_WIDTH) ? 5'(MAX_WIDTH)
                                                             : in_data_i.min_width;

  // one digit a cycle: divide by ten through the reciprocal, or take a nibble
  assign prod     = {32'b0, mag_q} * {32'b0, itp_pkg::Recip10};
  assign quot     = 32'(prod >> itp_pkg::Recip10Shr);
  assign dec_rem  = mag_q - (quot << 3) - (quot << 1);
  assign digit    = hex_q ? mag_q[3:0] : dec_rem[3:0];
  assign mag_next = hex_q ? (mag_q >> 4) : quot;

  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    cnt_d   = cnt_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          mag_d   = neg_in ? (32'd0 - in_data_i.value) : in_data_i.value;
          cnt_d   = '0;
          state_d = StConv;
        end
      end
      StConv: begin
        mag_d = mag_next;
        cnt_d = cnt_q + 1'b1;
        if (mag_next == '0) begin
          state_d = StPush;
        end
      end
      StPush: begin
        if (!job_full_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // payload side of the job
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    if (accept) begin
      hex_q          <= hex_in;
      job_q.neg      <= neg_in;
      job_q.upper    <= (in_data_i.mode == itp_pkg::ModeHexUp);
      job_q.zero_pad <= in_data_i.zero_pad;
      job_q.width    <= width_sat;
    end
    if (state_q == StConv) begin
      job_q.digits[cnt_q] <= digit;
      job_q.n_digits      <= cnt_q + 1'b1;
    end
  end

  assign job_push_o = (state_q == StPush) && !job_full_i;
  assign job_o      = job_q;

`ifndef SYNTH
  a_digit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StConv) |-> (cnt_q < DigW'(itp_pkg::MaxDigits)))
    else $error("digit count overran the digit buffer");
`endif

endmodule

// ----- hw/rtl/itp_back.sv -----
`timescale 1ns / 1ps

module itp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_empty_i,
  input  itp_pkg::job_t job_i,
  output logic          job_pop_o,
  output logic          empty,
  input  logic          pop,
  output itp_pkg::out_t out_data_o
);

  localparam int unsigned DigW = itp_pkg::DigW;

  logic          busy_q, busy_d;
  logic [4:0]    rem_q, rem_d;
  logic          out_valid_q, out_valid_d;
  itp_pkg::out_t out_q;

  logic [4:0]      len, total, rem_m1;
  logic [DigW-1:0] dig_idx;
  logic [7:0]      chr;
  logic            emit;

  // text length of the head job
  assign len   = 5'(job_i.n_digits) + {4'b0, job_i.neg};
  assign total = (len > job_i.width) ? len : job_i.width;

  // character at the current position, counted down from the end
  assign rem_m1  = rem_q - 5'd1;
  assign dig_idx = rem_m1[DigW-1:0];
  always_comb begin
    if (rem_q > len) begin
      chr = job_i.zero_pad ? itp_pkg::CharZero : itp_pkg::CharSpace;
    end else if (job_i.neg && (rem_q == len)) begin
      chr = itp_pkg::CharMinus;
    end else begin
      chr = itp_pkg::digit_char(job_i.digits[dig_idx], job_i.upper);
    end
  end

  assign emit      = busy_q && (!out_valid_q || pop);
  assign job_pop_o = emit && (rem_q == 5'd1);

  always_comb begin
    busy_d      = busy_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q;
    if (pop && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    if (!busy_q && !job_empty_i) begin
      busy_d = 1'b1;
      rem_d  = total;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      rem_d       = rem_m1;
      if (rem_q == 5'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output beat register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.char_code <= chr;
      out_q.last_char <= (rem_q == 5'd1);
    end
  end

  assign empty      = !out_valid_q;
  assign out_data_o = out_q;

`ifndef SYNTH
  a_busy_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q != 5'd0))
    else $error("active job with no characters left");
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> (out_valid_q && out_q.last_char))
    else $error("job retired without a last character");
`endif

endmodule

// ----- hw/rtl/integer_to_padded_text.sv -----
// Flow: the digit extractor breaks an accepted number into its digits (1 to 10), then
// hands the job to the queue once it has room; the back end turns it into characters.
// Throughput: one character per cycle from the output register while a job is active
// and pop keeps up; the front takes a new number only once its job is handed off, and
// the back end a new job only after its last one; the slower sets the sustained rate.
// Reset: rst_ni is asynchronous active low and empties the job queue and output.
`timescale 1ns / 1ps

module integer_to_padded_text #(
  parameter int unsigned MAX_WIDTH = itp_pkg::MaxWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  itp_pkg::in_t  in_data_i,
  output logic          empty,
  input  logic          pop,
  output itp_pkg::out_t out_data_o
);

  logic          job_push, job_full, job_pop, job_empty;
  itp_pkg::job_t job_wr, job_rd;

  // digit extraction
  itp_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_data_i (in_data_i),
    .job_push_o(job_push),
    .job_full_i(job_full),
    .job_o     (job_wr)
  );

  // job queue
  itp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .wdata_i(job_wr),
    .full_o (job_full),
    .pop_i  (job_pop),
    .empty_o(job_empty),
    .rdata_o(job_rd)
  );

  // character emission
  itp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_empty_i(job_empty),
    .job_i      (job_rd),
    .job_pop_o  (job_pop),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o)
  );

endmodule
